// ===== design/kps_pkg.sv =====
// shared types, constants and helper functions for the matrix keypad scanner
package kps_pkg;

   localparam int MAX_ROWS = 4;
   localparam int MAX_COLS = 4;
   localparam int ROW_W = 4;
   localparam int COL_W = 4;
   localparam int CNT_W = 3;
   localparam int TICK_W = 8;
   localparam int CODE_W = 8;
   localparam int MAP_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int ROW_IDX_W = 2;
   localparam int KEY_IDX_W = 5;

   localparam logic [CNT_W-1:0] ROWS_RESET = CNT_W'(4);
   localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(4);
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 3'd0,
      CSR_NUM_COLS = 3'd1,
      CSR_DEBOUNCE = 3'd2,
      CSR_KEYMAP_LO = 3'd3,
      CSR_KEYMAP_HI = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_RELEASE = 3'd0,
      PH_PRESS = 3'd1,
      PH_DEBOUNCE = 3'd2,
      PH_CONFIRM = 3'd3,
      PH_SCAN = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0] num_rows;
      logic [CNT_W-1:0] num_cols;
      logic [TICK_W-1:0] debounce_ticks;
      logic [2*MAP_W-1:0] keymap;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_drive;
      logic key_ready;
      logic [CODE_W-1:0] key_code;
   } res_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxv);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [ROW_IDX_W-1:0] lowest_bit(input logic [COL_W-1:0] m);
      logic [ROW_IDX_W-1:0] r;
      r = '0;
      for (int i = COL_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = ROW_IDX_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] drive_one(input logic [ROW_IDX_W-1:0] r);
      return ~(ROW_W'(1) << r);
   endfunction

endpackage

// ===== design/kps_ctrl.sv =====
// scan state machine: release wait, press detect, debounce, confirm and row scan
module kps_ctrl
   import kps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [COL_W-1:0] col_levels,
   input  cfg_type cfg,
   output res_type result
);

   phase_type phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;

   logic [CNT_W-1:0] nr, nc;
   logic [COL_W-1:0] active_cols, lows;
   logic [ROW_W-1:0] active_rows, drive_all;
   logic any_low, row_hit, row_more;
   logic [ROW_IDX_W-1:0] row_next, low_col;
   logic [KEY_IDX_W-1:0] key_idx;
   logic [CODE_W-1:0] key_byte;
   logic [TICK_W-1:0] tick_dec;

   assign nr = clamp_count(cfg.num_rows, CNT_W'(MAX_ROWS));
   assign nc = clamp_count(cfg.num_cols, CNT_W'(MAX_COLS));
   assign active_cols = COL_W'((5'd1 << nc) - 5'd1);
   assign active_rows = ROW_W'((5'd1 << nr) - 5'd1);
   assign lows = ~col_levels & active_cols;
   assign any_low = (lows != '0);
   assign drive_all = ~active_rows;
   assign row_hit = (CNT_W'(row_ff) < nr) && any_low;
   assign row_more = (CNT_W'(row_ff) + CNT_W'(1)) < nr;
   assign row_next = row_ff + ROW_IDX_W'(1);
   assign low_col = lowest_bit(lows);
   assign key_idx = KEY_IDX_W'(nc) * KEY_IDX_W'(row_ff) + KEY_IDX_W'(low_col);
   assign key_byte = (key_idx < KEY_IDX_W'(16)) ?
                     cfg.keymap[{key_idx[3:0], 3'b000} +: CODE_W] : '0;
   assign tick_dec = (tick_ff != '0) ? tick_ff - TICK_W'(1) : '0;

   // next state
   always_comb begin
      phase_in = phase_ff;
      tick_in = tick_ff;
      row_in = row_ff;
      unique case (phase_ff)
         PH_PRESS: begin
            if (any_low) begin
               if (cfg.debounce_ticks == '0) begin
                  phase_in = PH_CONFIRM;
               end else begin
                  tick_in = cfg.debounce_ticks;
                  phase_in = PH_DEBOUNCE;
               end
            end
         end
         PH_DEBOUNCE: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               phase_in = PH_CONFIRM;
            end
         end
         PH_CONFIRM: begin
            if (any_low) begin
               row_in = '0;
               phase_in = PH_SCAN;
            end else begin
               phase_in = PH_PRESS;
            end
         end
         PH_SCAN: begin
            if (row_hit) begin
               phase_in = PH_RELEASE;
            end else if (row_more) begin
               row_in = row_next;
            end else begin
               phase_in = PH_RELEASE;
            end
         end
         default: begin
            phase_in = any_low ? PH_RELEASE : PH_PRESS;
         end
      endcase
   end

   // outputs
   always_comb begin
      result.row_drive = drive_all;
      result.key_ready = 1'b0;
      result.key_code = '0;
      unique case (phase_ff)
         PH_CONFIRM: begin
            if (any_low) begin
               result.row_drive = drive_one('0);
            end
         end
         PH_SCAN: begin
            if (row_hit) begin
               result.key_ready = 1'b1;
               result.key_code = key_byte;
            end else if (row_more) begin
               result.row_drive = drive_one(row_next);
            end else begin
               result.key_ready = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASE;
         tick_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== design/matrix_keypad_scanner.sv =====
// top level: configuration registers, input register, scan control and result register
//
// Matrix keypad scanner with debounce. Each item on the req_ channel is one
// column sample taken under the row drive of the previous result; every item
// gives exactly one result on the rsp_ channel, carrying the row drive for the
// next sample and, when a scan ends, key_ready with the keymap byte (0 if no
// key was found). An item passes an input register and one step of the scan
// state machine into the result register, from which it shows on the rsp_ ports;
// one item is accepted every cycle while the result side keeps up. Configuration
// is written through csr_write/csr_index/csr_wdata by the user, who must do so
// only while no item is in flight, as the block does not enforce it; it then
// applies from the next item.
module matrix_keypad_scanner
   import kps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [COL_W-1:0] req_col_levels,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [ROW_W-1:0] rsp_row_drive,
   output logic rsp_key_ready,
   output logic [CODE_W-1:0] rsp_key_code,
   input  logic csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic in_valid_ff, in_valid_in;
   logic [COL_W-1:0] in_col_ff;
   logic out_valid_ff, out_valid_in;
   res_type out_ff;
   res_type step_res;
   logic advance, accept;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   kps_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .col_levels(in_col_ff),
      .cfg(cfg_ff),
      .result(step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_rows <= ROWS_RESET;
         cfg_ff.num_cols <= COLS_RESET;
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.keymap <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_ROWS:  cfg_ff.num_rows <= csr_wdata[CNT_W-1:0];
            CSR_NUM_COLS:  cfg_ff.num_cols <= csr_wdata[CNT_W-1:0];
            CSR_DEBOUNCE:  cfg_ff.debounce_ticks <= csr_wdata[TICK_W-1:0];
            CSR_KEYMAP_LO: cfg_ff.keymap[MAP_W-1:0] <= csr_wdata[MAP_W-1:0];
            CSR_KEYMAP_HI: cfg_ff.keymap[2*MAP_W-1:MAP_W] <= csr_wdata[MAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_col_ff <= req_col_levels;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_row_drive = out_ff.row_drive;
   assign rsp_key_ready = out_ff.key_ready;
   assign rsp_key_code = out_ff.key_code;

endmodule

// ===== design/kps_checker.sv =====
// port-level assertions for the matrix keypad scanner, bound to the top level
module kps_checker
   import kps_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [ROW_W-1:0] rsp_row_drive,
   input logic rsp_key_ready,
   input logic [CODE_W-1:0] rsp_key_code
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_drive)
         && $stable(rsp_key_ready) && $stable(rsp_key_code))
      else $error("stalled result item changed");

   // no code without a finished scan
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_key_ready |-> rsp_key_code == '0)
      else $error("key code set without key_ready");

   // some row is always driven low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_drive != '1)
      else $error("no row driven low");

   // after a finished scan all active rows go back low, row 0 included
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_ready |-> !rsp_row_drive[0])
      else $error("row 0 not driven low after scan");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_row_drive(rsp_row_drive),
   .rsp_key_ready(rsp_key_ready),
   .rsp_key_code(rsp_key_code)
);
